// File: rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared types, widths and status codes of the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int FIELD_OFF_W = 16;
  localparam int VER_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int OUT_DATA_W  = 4 * FIELD_OFF_W + 2 * VER_W;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN         = 3'd0,
    ST_MORE        = 3'd1,
    ST_DONE        = 3'd2,
    ST_BAD_METHOD  = 3'd3,
    ST_BAD_REQUEST = 3'd4
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       packet_end;
  } byte_req_t;

endpackage

// File: rtl/hrlp_in_stage.sv
// ----------------------------------------------------------------------------
// HTTP request line parser input stage
// Registers one request byte and holds it until the parser core takes it.
// ----------------------------------------------------------------------------
module hrlp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               packet_end_i,
  output hrlp_pkg::byte_req_t req_o,
  input  logic               req_ready_i
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  assign ready_o = !valid_q || req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_byte_i;
      last_q <= packet_end_i;
    end
  end

  assign req_o = '{valid: valid_q, data_byte: data_q, packet_end: last_q};

endmodule

// File: rtl/hrlp_core.sv
// ----------------------------------------------------------------------------
// HTTP request line parser core
// Per-byte state machine of the request line with its result register.
// ----------------------------------------------------------------------------
module hrlp_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hrlp_pkg::byte_req_t               req_i,
  output logic                              req_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hrlp_pkg::STATUS_W-1:0]     status_o,
  output logic [hrlp_pkg::OUT_DATA_W-1:0]   result_o
);

  typedef enum logic [3:0] {
    PH_START, PH_METHOD, PH_SPACES_URI, PH_URI, PH_H, PH_HT, PH_HTT, PH_HTTP,
    PH_SLASH, PH_FIRST_MAJOR, PH_MAJOR, PH_FIRST_MINOR, PH_MINOR,
    PH_SPACES_AFTER, PH_ALMOST
  } phase_e;

  localparam logic [hrlp_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;

  function automatic logic is_method_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] sat_ver(logic [7:0] acc, logic [7:0] c);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, c[3:0]};
    return (v > 12'd255) ? 8'hff : v[7:0];
  endfunction

  phase_e                           phase_q, phase_d;
  logic [hrlp_pkg::OFFSET_BITS-1:0] offset_q, offset_d;
  logic [hrlp_pkg::OFFSET_BITS-1:0] method_end_q, method_end_d;
  logic [hrlp_pkg::OFFSET_BITS-1:0] uri_begin_q, uri_begin_d;
  logic [hrlp_pkg::OFFSET_BITS-1:0] uri_finish_q, uri_finish_d;
  logic [hrlp_pkg::OFFSET_BITS-1:0] line_finish_q, line_finish_d;
  logic [7:0]                       major_q, major_d;
  logic [7:0]                       minor_q, minor_d;
  logic [hrlp_pkg::OFFSET_BITS-1:0] pos;
  logic [7:0]                       c;
  logic [7:0]                       c_low;
  hrlp_pkg::status_e                st;
  logic [hrlp_pkg::OUT_DATA_W-1:0]  result_d;
  logic                             out_valid_q;
  hrlp_pkg::status_e                status_q;
  logic [hrlp_pkg::OUT_DATA_W-1:0]  result_q;
  logic                             fire;

  assign req_ready_o = !out_valid_q || out_ready_i;
  assign fire        = req_i.valid && req_ready_o;
  assign c           = req_i.data_byte;
  assign c_low       = c | 8'h20;
  assign pos         = (phase_q == PH_START) ? '0 : offset_q;

  always_comb begin
    phase_d       = phase_q;
    method_end_d  = method_end_q;
    uri_begin_d   = uri_begin_q;
    uri_finish_d  = uri_finish_q;
    line_finish_d = line_finish_q;
    major_d       = major_q;
    minor_d       = minor_q;
    st            = hrlp_pkg::ST_RUN;
    unique case (phase_q)
      PH_METHOD: begin
        if (c == hrlp_pkg::CH_SPACE) begin
          method_end_d = pos;
          phase_d      = PH_SPACES_URI;
        end else if (!is_method_char(c)) begin
          st = hrlp_pkg::ST_BAD_METHOD;
        end
      end
      PH_SPACES_URI: begin
        if (c == "/" || (c_low >= "a" && c_low <= "z")) begin
          uri_begin_d = pos;
          phase_d     = PH_URI;
        end else if (c != hrlp_pkg::CH_SPACE) begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      PH_URI: begin
        if (c == hrlp_pkg::CH_SPACE) begin
          uri_finish_d = pos;
          phase_d      = PH_H;
        end
      end
      PH_H: begin
        if (c == "H") phase_d = PH_HT; else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      PH_HT: begin
        if (c == "T") phase_d = PH_HTT; else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      PH_HTT: begin
        if (c == "T") phase_d = PH_HTTP; else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      PH_HTTP: begin
        if (c == "P") phase_d = PH_SLASH; else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      PH_SLASH: begin
        if (c == "/") phase_d = PH_FIRST_MAJOR; else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      PH_FIRST_MAJOR: begin
        if (c >= "1" && c <= "9") begin
          major_d = {4'h0, c[3:0]};
          phase_d = PH_MAJOR;
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      PH_MAJOR: begin
        if (c == ".") begin
          phase_d = PH_FIRST_MINOR;
        end else if (is_digit(c)) begin
          major_d = sat_ver(major_q, c);
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      PH_FIRST_MINOR: begin
        if (is_digit(c)) begin
          minor_d = {4'h0, c[3:0]};
          phase_d = PH_MINOR;
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      PH_MINOR, PH_SPACES_AFTER: begin
        if (c == hrlp_pkg::CH_CR) begin
          line_finish_d = pos;
          phase_d       = PH_ALMOST;
        end else if (c == hrlp_pkg::CH_LF) begin
          line_finish_d = pos;
          st            = hrlp_pkg::ST_DONE;
        end else if (c == hrlp_pkg::CH_SPACE) begin
          phase_d = PH_SPACES_AFTER;
        end else if (phase_q == PH_MINOR && is_digit(c)) begin
          minor_d = sat_ver(minor_q, c);
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      PH_ALMOST: begin
        st = (c == hrlp_pkg::CH_LF) ? hrlp_pkg::ST_DONE : hrlp_pkg::ST_BAD_REQUEST;
      end
      default: begin
        phase_d = PH_START;
        if (c != hrlp_pkg::CH_LF && c != hrlp_pkg::CH_CR) begin
          if (!is_method_char(c)) begin
            st = hrlp_pkg::ST_BAD_METHOD;
          end else begin
            phase_d = PH_METHOD;
          end
        end
      end
    endcase

    if (st != hrlp_pkg::ST_RUN) begin
      phase_d = PH_START;
    end else if (req_i.packet_end) begin
      st = hrlp_pkg::ST_MORE;
    end

    if (phase_d == PH_START) begin
      offset_d = '0;
    end else begin
      offset_d = (pos == OFF_MAX) ? OFF_MAX : pos + 1'b1;
    end

    result_d = '0;
    if (st == hrlp_pkg::ST_DONE) begin
      result_d = {minor_d, major_d,
                  hrlp_pkg::FIELD_OFF_W'(line_finish_d),
                  hrlp_pkg::FIELD_OFF_W'(uri_finish_d),
                  hrlp_pkg::FIELD_OFF_W'(uri_begin_d),
                  hrlp_pkg::FIELD_OFF_W'(method_end_d)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_START;
      offset_q      <= '0;
      method_end_q  <= '0;
      uri_begin_q   <= '0;
      uri_finish_q  <= '0;
      line_finish_q <= '0;
      major_q       <= '0;
      minor_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (fire) begin
        phase_q       <= phase_d;
        offset_q      <= offset_d;
        method_end_q  <= method_end_d;
        uri_begin_q   <= uri_begin_d;
        uri_finish_q  <= uri_finish_d;
        line_finish_q <= line_finish_d;
        major_q       <= major_d;
        minor_q       <= minor_d;
      end
      if (req_ready_o) begin
        out_valid_q <= req_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= st;
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_o    = result_q;

endmodule

// File: rtl/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// HTTP request line parser
// Parses an HTTP request line one byte at a time and reports a status for
// every byte, with method length, URI offsets, line end and version on done.
//
// Channel  Direction  Contents
// s_axis   in         tdata[7:0] data_byte, tlast packet_end
// m_axis   out        tuser[2:0] parse_status, tdata method_length,
//                     uri_begin, uri_finish, line_finish, version_major,
//                     version_minor
//
// One byte is taken every cycle while the result is not stalled; each request
// gives its result through the input register and the result register.
// Reset is asynchronous and active low and returns the parser to start.
// A stalled result holds the core, and the input register then fills.
// ----------------------------------------------------------------------------
module http_request_line_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte
  input  logic                            s_axis_tlast,  // packet_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // method_length, uri_begin, uri_finish, line_finish, version_major,
  // version_minor
  output logic [hrlp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [hrlp_pkg::STATUS_W-1:0]   m_axis_tuser   // parse_status
);

  hrlp_pkg::byte_req_t req;
  logic                req_ready;

  hrlp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .packet_end_i (s_axis_tlast),
    .req_o        (req),
    .req_ready_i  (req_ready)
  );

  hrlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (m_axis_tuser),
    .result_o    (m_axis_tdata)
  );

endmodule

// File: rtl/hrlp_checker.sv
// ----------------------------------------------------------------------------
// HTTP request line parser checker
// Port-level checks of the parser results, bound to the top level.
// ----------------------------------------------------------------------------
module hrlp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [7:0]                      s_axis_tdata,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hrlp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [hrlp_pkg::STATUS_W-1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled result changed.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= hrlp_pkg::ST_BAD_REQUEST)
    else $error("Result status out of range.");

  a_zero_unless_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != hrlp_pkg::ST_DONE |-> m_axis_tdata == '0)
    else $error("Result fields set without done.");

  a_major_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == hrlp_pkg::ST_DONE |->
      m_axis_tdata[71:64] != 8'h00)
    else $error("Done with a zero major version.");

  a_idle_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// HTTP request line parser testbench
// Streams directed and randomly built request lines into the parser, one
// byte per request, and checks every status and field result against a
// byte-level predictor of the parse state machine kept inside this module.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic [4:0] {
    P_START, P_METHOD, P_URI_SPACES, P_URI, P_H, P_HT, P_HTT, P_HTTP, P_SLASH,
    P_MAJOR_FIRST, P_MAJOR, P_MINOR_FIRST, P_MINOR, P_TRAIL_SPACES,
    P_LF_AFTER_CR
  } parse_phase_e;

  typedef struct packed {
    logic [hrlp_pkg::VER_W-1:0]       ver_minor;
    logic [hrlp_pkg::VER_W-1:0]       ver_major;
    logic [hrlp_pkg::FIELD_OFF_W-1:0] line_end;
    logic [hrlp_pkg::FIELD_OFF_W-1:0] uri_end;
    logic [hrlp_pkg::FIELD_OFF_W-1:0] uri_start;
    logic [hrlp_pkg::FIELD_OFF_W-1:0] method_len;
  } line_fields_t;

  typedef struct packed {
    hrlp_pkg::status_e status;
    line_fields_t      fields;
  } line_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hrlp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [hrlp_pkg::STATUS_W-1:0]   m_axis_tuser;

  parse_phase_e                     cur_phase;
  logic [hrlp_pkg::OFFSET_BITS-1:0] cur_offset;
  logic [hrlp_pkg::OFFSET_BITS-1:0] method_end_off;
  logic [hrlp_pkg::OFFSET_BITS-1:0] uri_start_off;
  logic [hrlp_pkg::OFFSET_BITS-1:0] uri_end_off;
  logic [hrlp_pkg::OFFSET_BITS-1:0] line_end_off;
  logic [hrlp_pkg::VER_W-1:0]       major_acc;
  logic [hrlp_pkg::VER_W-1:0]       minor_acc;

  line_result_t expected_line_results[$];
  logic [7:0]   line_bytes[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int lines_done = 0;
  int lines_rejected = 0;
  int packet_ends_inside = 0;

  http_request_line_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic is_method_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [hrlp_pkg::VER_W-1:0] add_version_digit(
      input logic [hrlp_pkg::VER_W-1:0] acc, input logic [7:0] c);
    int v;
    v = 10 * int'(acc) + int'(c - "0");
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic void reset_parser_model();
    cur_phase = P_START;
    cur_offset = '0;
    method_end_off = '0;
    uri_start_off = '0;
    uri_end_off = '0;
    line_end_off = '0;
    major_acc = '0;
    minor_acc = '0;
  endfunction

  function automatic line_result_t predict_line_step(input logic [7:0] c, input logic last);
    line_result_t                     r;
    parse_phase_e                     ph;
    hrlp_pkg::status_e                st;
    logic [hrlp_pkg::OFFSET_BITS-1:0] pos;
    logic [7:0]                       lc;
    ph = cur_phase;
    st = hrlp_pkg::ST_RUN;
    pos = (ph == P_START) ? '0 : cur_offset;
    lc = c | 8'h20;
    case (ph)
      P_START: begin
        if (c != hrlp_pkg::CH_LF && c != hrlp_pkg::CH_CR) begin
          if (is_method_char(c)) ph = P_METHOD;
          else st = hrlp_pkg::ST_BAD_METHOD;
        end
      end
      P_METHOD: begin
        if (c == hrlp_pkg::CH_SPACE) begin
          method_end_off = pos;
          ph = P_URI_SPACES;
        end else if (!is_method_char(c)) begin
          st = hrlp_pkg::ST_BAD_METHOD;
        end
      end
      P_URI_SPACES: begin
        if (c == "/" || (lc >= "a" && lc <= "z")) begin
          uri_start_off = pos;
          ph = P_URI;
        end else if (c != hrlp_pkg::CH_SPACE) begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      P_URI: begin
        if (c == hrlp_pkg::CH_SPACE) begin
          uri_end_off = pos;
          ph = P_H;
        end
      end
      P_H:    if (c == "H") ph = P_HT;    else st = hrlp_pkg::ST_BAD_REQUEST;
      P_HT:   if (c == "T") ph = P_HTT;   else st = hrlp_pkg::ST_BAD_REQUEST;
      P_HTT:  if (c == "T") ph = P_HTTP;  else st = hrlp_pkg::ST_BAD_REQUEST;
      P_HTTP: if (c == "P") ph = P_SLASH; else st = hrlp_pkg::ST_BAD_REQUEST;
      P_SLASH: if (c == "/") ph = P_MAJOR_FIRST; else st = hrlp_pkg::ST_BAD_REQUEST;
      P_MAJOR_FIRST: begin
        if (c >= "1" && c <= "9") begin
          major_acc = 8'(c - "0");
          ph = P_MAJOR;
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      P_MAJOR: begin
        if (c == ".") ph = P_MINOR_FIRST;
        else if (is_digit(c)) major_acc = add_version_digit(major_acc, c);
        else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      P_MINOR_FIRST: begin
        if (is_digit(c)) begin
          minor_acc = 8'(c - "0");
          ph = P_MINOR;
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      P_MINOR, P_TRAIL_SPACES: begin
        if (c == hrlp_pkg::CH_CR) begin
          line_end_off = pos;
          ph = P_LF_AFTER_CR;
        end else if (c == hrlp_pkg::CH_LF) begin
          line_end_off = pos;
          st = hrlp_pkg::ST_DONE;
        end else if (c == hrlp_pkg::CH_SPACE) begin
          ph = P_TRAIL_SPACES;
        end else if (ph == P_MINOR && is_digit(c)) begin
          minor_acc = add_version_digit(minor_acc, c);
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      default: begin
        if (c == hrlp_pkg::CH_LF) st = hrlp_pkg::ST_DONE;
        else st = hrlp_pkg::ST_BAD_REQUEST;
      end
    endcase

    if (st != hrlp_pkg::ST_RUN) ph = P_START;
    else if (last) st = hrlp_pkg::ST_MORE;

    if (ph == P_START) cur_offset = '0;
    else cur_offset = (pos == '1) ? pos : pos + 1'b1;
    cur_phase = ph;

    r = '0;
    r.status = st;
    if (st == hrlp_pkg::ST_DONE) begin
      r.fields.method_len = hrlp_pkg::FIELD_OFF_W'(method_end_off);
      r.fields.uri_start = hrlp_pkg::FIELD_OFF_W'(uri_start_off);
      r.fields.uri_end = hrlp_pkg::FIELD_OFF_W'(uri_end_off);
      r.fields.line_end = hrlp_pkg::FIELD_OFF_W'(line_end_off);
      r.fields.ver_major = major_acc;
      r.fields.ver_minor = minor_acc;
    end
    return r;
  endfunction

  function automatic logic [7:0] random_non_space();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == hrlp_pkg::CH_SPACE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] b;
    b = 8'("A" + $urandom_range(0, 25));
    if ($urandom_range(0, 1)) b = b | 8'h20;
    return b;
  endfunction

  // Builds one request line, mostly well formed, into line_bytes.
  function automatic void build_request_line(input int uri_bytes);
    int n;
    line_bytes.delete();
    if ($urandom_range(1, 100) <= 10) begin
      n = $urandom_range(1, 3);
      repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(1, 100) <= 25) begin
      n = $urandom_range(1, 2);
      repeat (n) line_bytes.push_back($urandom_range(0, 1) ? hrlp_pkg::CH_CR : hrlp_pkg::CH_LF);
    end
    n = $urandom_range(1, 7);
    repeat (n) begin
      if ($urandom_range(0, 26) == 26) line_bytes.push_back("_");
      else line_bytes.push_back(8'("A" + $urandom_range(0, 25)));
    end
    n = $urandom_range(1, 3);
    repeat (n) line_bytes.push_back(hrlp_pkg::CH_SPACE);
    line_bytes.push_back($urandom_range(0, 1) ? 8'("/") : random_letter());
    repeat (uri_bytes) line_bytes.push_back(random_non_space());
    line_bytes.push_back(hrlp_pkg::CH_SPACE);
    line_bytes.push_back("H");
    line_bytes.push_back("T");
    line_bytes.push_back("T");
    line_bytes.push_back("P");
    line_bytes.push_back("/");
    line_bytes.push_back(8'("0" + $urandom_range(1, 9)));
    n = ($urandom_range(1, 100) <= 30) ? $urandom_range(1, 4) : 0;
    repeat (n) line_bytes.push_back(8'("0" + $urandom_range(0, 9)));
    line_bytes.push_back(".");
    n = ($urandom_range(1, 100) <= 30) ? $urandom_range(2, 5) : 1;
    repeat (n) line_bytes.push_back(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(1, 100) <= 30) begin
      n = $urandom_range(1, 2);
      repeat (n) line_bytes.push_back(hrlp_pkg::CH_SPACE);
    end
    if ($urandom_range(0, 1)) line_bytes.push_back(hrlp_pkg::CH_CR);
    line_bytes.push_back(hrlp_pkg::CH_LF);
    if ($urandom_range(1, 100) <= 15)
      line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while ($urandom_range(1, 100) <= tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = b;
    s_axis_tlast = last;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_line_results.push_back(predict_line_step(b, last));
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && i == s.len() - 1);
  endtask

  task automatic send_built_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i], $urandom_range(1, 100) <= 6);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_line_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_text("\r\n_ a\r HTTP/1.0\n", 1'b1);
    send_text("A /", 1'b1);
    send_text(" X", 1'b0);
  endtask

  task automatic test_random_lines(input int tx_pct, input int rx_pct, input int n_bytes);
    int stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_request_line($urandom_range(0, 12));
      send_built_line();
    end
  endtask

  task automatic test_output_stall();
    int stop_at;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_cycles = 300;
    stop_at = bytes_sent + 50;
    while (bytes_sent < stop_at) begin
      build_request_line($urandom_range(0, 6));
      send_built_line();
    end
  endtask

  task automatic note_mismatch(input string what, input line_result_t want,
                               input line_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected status %0d len %0d uri %0d..%0d end %0d ver %0d.%0d,",
               $realtime, what, want.status, want.fields.method_len,
               want.fields.uri_start, want.fields.uri_end, want.fields.line_end,
               want.fields.ver_major, want.fields.ver_minor);
      $display("    got status %0d len %0d uri %0d..%0d end %0d ver %0d.%0d",
               got.status, got.fields.method_len, got.fields.uri_start,
               got.fields.uri_end, got.fields.line_end, got.fields.ver_major,
               got.fields.ver_minor);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(1, 100) > rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    line_result_t got;
    line_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = hrlp_pkg::status_e'(m_axis_tuser);
      got.fields = line_fields_t'(m_axis_tdata);
      if (expected_line_results.size() == 0) begin
        note_mismatch("result with no request pending", '0, got);
      end else begin
        want = expected_line_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
        if (want.status == hrlp_pkg::ST_DONE) lines_done++;
        if (want.status == hrlp_pkg::ST_BAD_METHOD ||
            want.status == hrlp_pkg::ST_BAD_REQUEST) lines_rejected++;
        if (want.status == hrlp_pkg::ST_MORE) packet_ends_inside++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_line_results.size());
      $display("http_request_line_parser: mismatch");
      $finish;
    end
  end

  initial begin
    reset_parser_model();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_lines(33, 79, 130);
    test_random_lines(79, 33, 130);
    test_output_stall();
    test_random_lines(0, 0, 90);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes: %0d lines completed, %0d rejected, %0d packet ends inside.",
             bytes_sent, lines_done, lines_rejected, packet_ends_inside);
    $display("Covered both idle mixes, an unthrottled run and a long output stall.");
    if (mismatch_count == 0) begin
      $display("http_request_line_parser: match");
    end else begin
      $display("%0d results differed from the prediction.", mismatch_count);
      $display("http_request_line_parser: mismatch");
    end
    $finish;
  end

endmodule
